@@ src/grt_pkg.sv @@
package grt_pkg;

  // Field widths of the channels and registers
  localparam int OPCODE_W   = 3;
  localparam int ID_FIELD_W = 16;
  localparam int SIZE_W     = 48;
  localparam int PRIO_W     = 2;
  localparam int FRAME_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 9;
  localparam int USAGE_W    = 64;
  localparam int RATIO_W    = 17;
  localparam int IDLE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W     = SIZE_W + RATIO_W;
  localparam int FRAC_W     = 16;

  // Default sizing
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_EVICT_DEF   = 64;
  localparam int ID_BITS_DEF     = 16;

  // Configuration reset values
  localparam logic [SIZE_W-1:0]  BUDGET_RST    = '0;
  localparam logic [RATIO_W-1:0] THRESHOLD_RST = 17'd58982;
  localparam logic [RATIO_W-1:0] TARGET_RST    = 17'd52429;
  localparam logic [IDLE_W-1:0]  IDLE_RST      = 32'd3;

  // Highest priority level, never evicted
  localparam logic [PRIO_W-1:0] PRIO_MAX = 2'd3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_REGISTER      = 3'd0,
    OP_UNREGISTER    = 3'd1,
    OP_MARK_USED     = 3'd2,
    OP_MAKE_RESIDENT = 3'd3,
    OP_FRAME_START   = 3'd4,
    OP_FRAME_END     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUDGET    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_TARGET    = 2'd2,
    CFG_IDLE      = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_en;
    logic reg_wr;
    logic frame_wr;
    logic mark_wr;
    logic unreg_rd;
    logic unreg_acct;
    logic unreg_wr;
    logic fe_mul;
    logic fe_cmp;
    logic fe_apply;
    logic ev_out;
    logic res_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic pre_err;
    logic scan_done;
    logic hit;
    logic fe_ok;
    logic npick_zero;
    logic ev_last;
    logic out_free;
  } sts_t;

endpackage

@@ src/grt_in_if.sv @@
interface grt_in_if;
  logic                                valid;
  logic                                ready;
  logic [grt_pkg::OPCODE_W-1:0]        opcode;
  logic [grt_pkg::ID_FIELD_W-1:0]      resource_id;
  logic [grt_pkg::SIZE_W-1:0]          resource_size;
  logic [grt_pkg::PRIO_W-1:0]          resource_priority;
  logic [grt_pkg::FRAME_W-1:0]         frame_number;
  logic [grt_pkg::FRAME_W-1:0]         fence_value;

  modport source (
    output valid, opcode, resource_id, resource_size, resource_priority,
           frame_number, fence_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, resource_id, resource_size, resource_priority,
           frame_number, fence_value,
    output ready
  );
endinterface

@@ src/grt_out_if.sv @@
interface grt_out_if;
  logic                            valid;
  logic                            ready;
  logic [grt_pkg::STATUS_W-1:0]    status;
  logic                            evicted_valid;
  logic [grt_pkg::ID_FIELD_W-1:0]  evicted_id;
  logic [grt_pkg::USAGE_W-1:0]     usage_total;
  logic [grt_pkg::TOTAL_W-1:0]     resident_total;
  logic [grt_pkg::TOTAL_W-1:0]     evicted_total;
  logic                            last;

  modport source (
    output valid, status, evicted_valid, evicted_id, usage_total, resident_total,
           evicted_total, last,
    input  ready
  );
  modport sink (
    input  valid, status, evicted_valid, evicted_id, usage_total, resident_total,
           evicted_total, last,
    output ready
  );
endinterface

@@ src/gpu_residency_eviction_table_core.sv @@
// Register, frame start and rejected items pass from dispatch to the result state and its beat.
// Unregister, mark used and make resident walk the table one entry per cycle; an unregister
// hit then copies the last entry into the freed slot. Frame end checks the usage ratios, walks
// the table, then gives one beat per evicted entry; table memory read port sets the walk rate.
// One item is in work at a time; the output register lets the next item in while a beat waits.
// Reset clears counts, usage, frame and the output; table contents stay undefined, no sweep.
module gpu_residency_eviction_table_core #(
  parameter int TABLE_DEPTH = grt_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_EVICT   = grt_pkg::MAX_EVICT_DEF,
  parameter int ID_BITS     = grt_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  grt_in_if.sink                        in_ch,
  grt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [grt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data
);

  grt_pkg::cmd_t cmd;
  grt_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  grt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_EVICT   (MAX_EVICT),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_ch.opcode),
    .in_resource_id       (in_ch.resource_id),
    .in_resource_size     (in_ch.resource_size),
    .in_resource_priority (in_ch.resource_priority),
    .in_frame_number      (in_ch.frame_number),
    .in_fence_value       (in_ch.fence_value),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_status           (out_ch.status),
    .out_evicted_valid    (out_ch.evicted_valid),
    .out_evicted_id       (out_ch.evicted_id),
    .out_usage_total      (out_ch.usage_total),
    .out_resident_total   (out_ch.resident_total),
    .out_evicted_total    (out_ch.evicted_total),
    .out_last             (out_ch.last)
  );

endmodule

@@ src/grt_ctrl.sv @@
module grt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  grt_pkg::sts_t sts,
  output grt_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_SCAN     = 11'b000_0000_0100,
    S_UNREG_RD = 11'b000_0000_1000,
    S_UNREG_WR = 11'b000_0001_0000,
    S_FE_MUL   = 11'b000_0010_0000,
    S_FE_CMP   = 11'b000_0100_0000,
    S_FE_APPLY = 11'b000_1000_0000,
    S_EV_RD    = 11'b001_0000_0000,
    S_EV_OUT   = 11'b010_0000_0000,
    S_RESULT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence one item through table scans, eviction and result delivery
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        if (sts.pre_err) begin
          state_nxt = S_RESULT;
        end else begin
          case (sts.op) inside
            grt_pkg::OP_REGISTER: begin
              cmd.reg_wr = 1'b1;
              state_nxt  = S_RESULT;
            end
            grt_pkg::OP_UNREGISTER, grt_pkg::OP_MARK_USED,
            grt_pkg::OP_MAKE_RESIDENT: begin
              state_nxt = S_SCAN;
            end
            grt_pkg::OP_FRAME_START: begin
              cmd.frame_wr = 1'b1;
              state_nxt    = S_RESULT;
            end
            grt_pkg::OP_FRAME_END: begin
              state_nxt = S_FE_MUL;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          case (sts.op) inside
            grt_pkg::OP_UNREGISTER: begin
              state_nxt = sts.hit ? S_UNREG_RD : S_RESULT;
            end
            grt_pkg::OP_MARK_USED: begin
              cmd.mark_wr = sts.hit;
              state_nxt   = S_RESULT;
            end
            grt_pkg::OP_FRAME_END: begin
              state_nxt = S_FE_APPLY;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_UNREG_RD: begin
        cmd.unreg_rd   = 1'b1;
        cmd.unreg_acct = 1'b1;
        state_nxt      = S_UNREG_WR;
      end
      S_UNREG_WR: begin
        cmd.unreg_wr = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_FE_MUL: begin
        cmd.fe_mul = 1'b1;
        state_nxt  = S_FE_CMP;
      end
      S_FE_CMP: begin
        cmd.fe_cmp = 1'b1;
        state_nxt  = sts.fe_ok ? S_SCAN : S_RESULT;
      end
      S_FE_APPLY: begin
        cmd.fe_apply = 1'b1;
        state_nxt    = sts.npick_zero ? S_RESULT : S_EV_RD;
      end
      S_EV_RD: begin
        state_nxt = S_EV_OUT;
      end
      S_EV_OUT: begin
        if (sts.out_free) begin
          cmd.ev_out = 1'b1;
          state_nxt  = sts.ev_last ? S_IDLE : S_EV_RD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/grt_dpath.sv @@
module grt_dpath #(
  parameter int TABLE_DEPTH = grt_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_EVICT   = grt_pkg::MAX_EVICT_DEF,
  parameter int ID_BITS     = grt_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  grt_pkg::cmd_t                     cmd,
  output grt_pkg::sts_t                     sts,
  input  logic [grt_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [grt_pkg::ID_FIELD_W-1:0]    in_resource_id,
  input  logic [grt_pkg::SIZE_W-1:0]        in_resource_size,
  input  logic [grt_pkg::PRIO_W-1:0]        in_resource_priority,
  input  logic [grt_pkg::FRAME_W-1:0]       in_frame_number,
  input  logic [grt_pkg::FRAME_W-1:0]       in_fence_value,
  input  logic                              cfg_we,
  input  logic [grt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [grt_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_evicted_valid,
  output logic [grt_pkg::ID_FIELD_W-1:0]    out_evicted_id,
  output logic [grt_pkg::USAGE_W-1:0]       out_usage_total,
  output logic [grt_pkg::TOTAL_W-1:0]       out_resident_total,
  output logic [grt_pkg::TOTAL_W-1:0]       out_evicted_total,
  output logic                              out_last
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W   = (ID_BITS < grt_pkg::ID_FIELD_W) ? ID_BITS : grt_pkg::ID_FIELD_W;
  localparam int PK_AW  = (MAX_EVICT > 1) ? $clog2(MAX_EVICT) : 1;
  localparam int PK_CW  = $clog2(MAX_EVICT + 1);
  localparam int SZ_W   = grt_pkg::SIZE_W;
  localparam int PR_W   = grt_pkg::PRIO_W;
  localparam int FR_W   = grt_pkg::FRAME_W;
  localparam int US_W   = grt_pkg::USAGE_W;
  localparam int PD_W   = grt_pkg::PROD_W;
  localparam int FRAC_W = grt_pkg::FRAC_W;
  localparam int IW     = ID_W + SZ_W + PR_W;
  localparam int LW     = 2 * FR_W;
  localparam int PW     = IDX_W + ID_W;

  // Table memories: id/size/priority, last frame/fence, resident mark
  logic [IW-1:0] mem_i [TABLE_DEPTH];
  logic [LW-1:0] mem_l [TABLE_DEPTH];
  logic          mem_res [TABLE_DEPTH];
  logic [PW-1:0] mem_pk [MAX_EVICT];

  logic [IW-1:0] mem_i_q;
  logic [LW-1:0] mem_l_q;
  logic          mem_res_q;
  logic [PW-1:0] pk_q;

  // Item registers
  grt_pkg::op_t         op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [SZ_W-1:0]      size_r, size_nxt;
  logic [PR_W-1:0]      prio_r, prio_nxt;
  logic [FR_W-1:0]      arg_r, arg_nxt;
  grt_pkg::status_t     pre_st_r, pre_st_nxt;

  // Configuration
  logic [SZ_W-1:0]              budget_r, budget_nxt;
  logic [grt_pkg::RATIO_W-1:0]  thr_r, thr_nxt;
  logic [grt_pkg::RATIO_W-1:0]  tgt_r, tgt_nxt;
  logic [grt_pkg::IDLE_W-1:0]   idle_r, idle_nxt;

  // Table bookkeeping
  logic [CNT_W-1:0] ent_cnt_r, ent_cnt_nxt;
  logic [FR_W-1:0]  cur_frame_r, cur_frame_nxt;
  logic [US_W-1:0]  usage_r, usage_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [CNT_W-1:0] ev_cnt_r, ev_cnt_nxt;

  // Scan state
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] dv_idx_r, dv_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             hit_res_r, hit_res_nxt;
  logic [SZ_W-1:0]  hit_size_r, hit_size_nxt;
  logic [US_W-1:0]  acc_r, acc_nxt;
  logic [US_W-1:0]  need_r, need_nxt;
  logic [PK_CW-1:0] npick_r, npick_nxt;
  logic [PK_CW-1:0] k_r, k_nxt;
  logic [PD_W-1:0]  prod_thr_r, prod_thr_nxt;
  logic [PD_W-1:0]  prod_tgt_r, prod_tgt_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  grt_pkg::status_t               out_st_r, out_st_nxt;
  logic                           out_evv_r, out_evv_nxt;
  logic [grt_pkg::ID_FIELD_W-1:0] out_id_r, out_id_nxt;
  logic [US_W-1:0]                out_usage_r, out_usage_nxt;
  logic [grt_pkg::TOTAL_W-1:0]    out_res_r, out_res_nxt;
  logic [grt_pkg::TOTAL_W-1:0]    out_ev_r, out_ev_nxt;
  logic                           out_last_r, out_last_nxt;

  // Combinational helpers
  logic [ID_W-1:0]      in_id;
  grt_pkg::status_t     load_st;
  logic [CNT_W-1:0]     last_cnt;
  logic [IDX_W-1:0]     raddr;
  logic [ID_W-1:0]      rd_id;
  logic [SZ_W-1:0]      rd_size;
  logic [PR_W-1:0]      rd_prio;
  logic [FR_W-1:0]      rd_last;
  logic [FR_W-1:0]      idle_age;
  logic                 stop;
  logic                 issue;
  logic                 proc;
  logic                 match;
  logic                 pick;
  logic                 mres;
  logic                 above_thr;
  logic                 above_tgt;
  logic [IDX_W-1:0]     pk_idx;
  logic [ID_W-1:0]      pk_id;
  logic                 ev_last;
  logic                 out_free;
  grt_pkg::status_t     res_st;

  logic                 mi_we;
  logic [IDX_W-1:0]     mi_waddr;
  logic [IW-1:0]        mi_wdata;
  logic                 ml_we;
  logic [IDX_W-1:0]     ml_waddr;
  logic [LW-1:0]        ml_wdata;
  logic                 mr_we;
  logic [IDX_W-1:0]     mr_waddr;
  logic                 mr_wdata;

  assign in_id    = in_resource_id[ID_W-1:0];
  assign last_cnt = ent_cnt_r - 1'b1;
  assign raddr    = cmd.unreg_rd ? last_cnt[IDX_W-1:0] : rd_idx_r[IDX_W-1:0];

  assign rd_id    = mem_i_q[IW-1 -: ID_W];
  assign rd_size  = mem_i_q[SZ_W+PR_W-1:PR_W];
  assign rd_prio  = mem_i_q[PR_W-1:0];
  assign rd_last  = mem_l_q[LW-1:FR_W];
  assign idle_age = cur_frame_r - rd_last;

  assign pk_idx   = pk_q[PW-1:ID_W];
  assign pk_id    = pk_q[ID_W-1:0];

  // Status of a new item known at acceptance
  always_comb begin
    case (in_opcode)
      grt_pkg::OP_REGISTER: begin
        if (in_id == '0) begin
          load_st = grt_pkg::ST_MISS;
        end else if (ent_cnt_r >= CNT_W'(TABLE_DEPTH)) begin
          load_st = grt_pkg::ST_FULL;
        end else begin
          load_st = grt_pkg::ST_DONE;
        end
      end
      grt_pkg::OP_UNREGISTER, grt_pkg::OP_MARK_USED, grt_pkg::OP_MAKE_RESIDENT: begin
        load_st = (in_id == '0) ? grt_pkg::ST_MISS : grt_pkg::ST_DONE;
      end
      grt_pkg::OP_FRAME_START, grt_pkg::OP_FRAME_END: begin
        load_st = grt_pkg::ST_DONE;
      end
      default: begin
        load_st = grt_pkg::ST_MISS;
      end
    endcase
  end

  // End an unregister or mark used scan on first match, a frame end scan once eviction has picked enough
  always_comb begin
    case (op_r)
      grt_pkg::OP_UNREGISTER, grt_pkg::OP_MARK_USED: begin
        stop = hit_r;
      end
      grt_pkg::OP_FRAME_END: begin
        stop = (acc_r >= need_r) || (npick_r == PK_CW'(MAX_EVICT));
      end
      default: begin
        stop = 1'b0;
      end
    endcase
  end

  assign issue = cmd.scan_en && !stop && (rd_idx_r < ent_cnt_r);
  assign proc  = dv_r && !stop;
  assign match = (rd_id == id_r);
  assign pick  = proc && (op_r == grt_pkg::OP_FRAME_END) && mem_res_q &&
                 (rd_prio != grt_pkg::PRIO_MAX) &&
                 (idle_age >= FR_W'(idle_r));
  assign mres  = proc && (op_r == grt_pkg::OP_MAKE_RESIDENT) && match && !mem_res_q;

  assign above_thr = {usage_r, FRAC_W'(0)} > (US_W + FRAC_W)'(prod_thr_r);
  assign above_tgt = {usage_r, FRAC_W'(0)} > (US_W + FRAC_W)'(prod_tgt_r);

  assign ev_last  = (PK_CW'(k_r + 1'b1) == npick_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (pre_st_r != grt_pkg::ST_DONE) begin
      res_st = pre_st_r;
    end else if (((op_r == grt_pkg::OP_UNREGISTER) || (op_r == grt_pkg::OP_MARK_USED) ||
                  (op_r == grt_pkg::OP_MAKE_RESIDENT)) && !hit_r) begin
      res_st = grt_pkg::ST_MISS;
    end else begin
      res_st = grt_pkg::ST_DONE;
    end
  end

  // Report to the controller
  always_comb begin
    sts.op         = op_r;
    sts.pre_err    = (pre_st_r != grt_pkg::ST_DONE);
    sts.scan_done  = stop || (!dv_r && (rd_idx_r >= ent_cnt_r));
    sts.hit        = hit_r;
    sts.fe_ok      = (budget_r != '0) && above_thr && above_tgt;
    sts.npick_zero = (npick_r == '0);
    sts.ev_last    = ev_last;
    sts.out_free   = out_free;
  end

  // Table write ports
  always_comb begin
    mi_we    = cmd.reg_wr || cmd.unreg_wr;
    mi_waddr = cmd.reg_wr ? ent_cnt_r[IDX_W-1:0] : hit_idx_r;
    mi_wdata = cmd.reg_wr ? {id_r, size_r, prio_r} : mem_i_q;

    ml_we    = cmd.reg_wr || cmd.mark_wr || cmd.unreg_wr;
    ml_waddr = cmd.reg_wr ? ent_cnt_r[IDX_W-1:0] : hit_idx_r;
    if (cmd.reg_wr) begin
      ml_wdata = {cur_frame_r, FR_W'(0)};
    end else if (cmd.mark_wr) begin
      ml_wdata = {cur_frame_r, arg_r};
    end else begin
      ml_wdata = mem_l_q;
    end

    mr_we = cmd.reg_wr || cmd.unreg_wr || mres || cmd.ev_out;
    if (cmd.reg_wr) begin
      mr_waddr = ent_cnt_r[IDX_W-1:0];
      mr_wdata = 1'b1;
    end else if (cmd.unreg_wr) begin
      mr_waddr = hit_idx_r;
      mr_wdata = mem_res_q;
    end else if (cmd.ev_out) begin
      mr_waddr = pk_idx;
      mr_wdata = 1'b0;
    end else begin
      mr_waddr = dv_idx_r;
      mr_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mi_we) begin
      mem_i[mi_waddr] <= mi_wdata;
    end
    mem_i_q <= mem_i[raddr];
  end

  always_ff @(posedge clk) begin
    if (ml_we) begin
      mem_l[ml_waddr] <= ml_wdata;
    end
    mem_l_q <= mem_l[raddr];
  end

  always_ff @(posedge clk) begin
    if (mr_we) begin
      mem_res[mr_waddr] <= mr_wdata;
    end
    mem_res_q <= mem_res[raddr];
  end

  // Picked entries of the current frame end
  always_ff @(posedge clk) begin
    if (pick) begin
      mem_pk[npick_r[PK_AW-1:0]] <= {dv_idx_r, rd_id};
    end
    pk_q <= mem_pk[k_r[PK_AW-1:0]];
  end

  // Next-state logic of the datapath registers
  always_comb begin
    op_nxt        = op_r;
    id_nxt        = id_r;
    size_nxt      = size_r;
    prio_nxt      = prio_r;
    arg_nxt       = arg_r;
    pre_st_nxt    = pre_st_r;
    budget_nxt    = budget_r;
    thr_nxt       = thr_r;
    tgt_nxt       = tgt_r;
    idle_nxt      = idle_r;
    ent_cnt_nxt   = ent_cnt_r;
    cur_frame_nxt = cur_frame_r;
    usage_nxt     = usage_r;
    res_cnt_nxt   = res_cnt_r;
    ev_cnt_nxt    = ev_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    dv_nxt        = 1'b0;
    dv_idx_nxt    = dv_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_res_nxt   = hit_res_r;
    hit_size_nxt  = hit_size_r;
    acc_nxt       = acc_r;
    need_nxt      = need_r;
    npick_nxt     = npick_r;
    k_nxt         = k_r;
    prod_thr_nxt  = prod_thr_r;
    prod_tgt_nxt  = prod_tgt_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_evv_nxt   = out_evv_r;
    out_id_nxt    = out_id_r;
    out_usage_nxt = out_usage_r;
    out_res_nxt   = out_res_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;

    // Capture the accepted beat
    if (cmd.load) begin
      op_nxt     = grt_pkg::op_t'(in_opcode);
      id_nxt     = in_id;
      size_nxt   = in_resource_size;
      prio_nxt   = in_resource_priority;
      arg_nxt    = (in_opcode == grt_pkg::OP_FRAME_START) ? in_frame_number : in_fence_value;
      pre_st_nxt = load_st;
    end

    // Configuration writes
    if (cfg_we) begin
      unique case (grt_pkg::cfg_idx_t'(cfg_index))
        grt_pkg::CFG_BUDGET:    budget_nxt = cfg_data[SZ_W-1:0];
        grt_pkg::CFG_THRESHOLD: thr_nxt    = cfg_data[grt_pkg::RATIO_W-1:0];
        grt_pkg::CFG_TARGET:    tgt_nxt    = cfg_data[grt_pkg::RATIO_W-1:0];
        grt_pkg::CFG_IDLE:      idle_nxt   = cfg_data[grt_pkg::IDLE_W-1:0];
        default:                budget_nxt = budget_r;
      endcase
    end

    // Restart the scan
    if (cmd.scan_clr) begin
      rd_idx_nxt = '0;
      hit_nxt    = 1'b0;
      acc_nxt    = '0;
      npick_nxt  = '0;
    end

    // Advance the read pointer
    if (issue) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
      dv_nxt     = 1'b1;
      dv_idx_nxt = rd_idx_r[IDX_W-1:0];
    end

    // Record a matching entry
    if (proc && match && (op_r != grt_pkg::OP_FRAME_END)) begin
      hit_nxt      = 1'b1;
      hit_idx_nxt  = dv_idx_r;
      hit_res_nxt  = mem_res_q;
      hit_size_nxt = rd_size;
    end

    // Bring an evicted match back
    if (mres) begin
      usage_nxt   = usage_r + US_W'(rd_size);
      res_cnt_nxt = res_cnt_r + 1'b1;
      ev_cnt_nxt  = ev_cnt_r - 1'b1;
    end

    // Pick an idle entry for eviction
    if (pick) begin
      npick_nxt = npick_r + 1'b1;
      acc_nxt   = acc_r + US_W'(rd_size);
    end

    // Append a new entry
    if (cmd.reg_wr) begin
      ent_cnt_nxt = ent_cnt_r + 1'b1;
      usage_nxt   = usage_r + US_W'(size_r);
      res_cnt_nxt = res_cnt_r + 1'b1;
    end

    if (cmd.frame_wr) begin
      cur_frame_nxt = arg_r;
    end

    // Drop the removed entry from the totals
    if (cmd.unreg_acct) begin
      if (hit_res_r) begin
        usage_nxt   = usage_r - US_W'(hit_size_r);
        res_cnt_nxt = res_cnt_r - 1'b1;
      end else begin
        ev_cnt_nxt  = ev_cnt_r - 1'b1;
      end
    end

    if (cmd.unreg_wr) begin
      ent_cnt_nxt = ent_cnt_r - 1'b1;
    end

    // Usage ratio products and eviction amount
    if (cmd.fe_mul) begin
      prod_thr_nxt = PD_W'(budget_r) * PD_W'(thr_r);
      prod_tgt_nxt = PD_W'(budget_r) * PD_W'(tgt_r);
    end

    if (cmd.fe_cmp) begin
      need_nxt = usage_r - US_W'(prod_tgt_r[PD_W-1:FRAC_W]);
    end

    if (cmd.fe_apply) begin
      usage_nxt   = usage_r - acc_r;
      res_cnt_nxt = res_cnt_r - CNT_W'(npick_r);
      ev_cnt_nxt  = ev_cnt_r + CNT_W'(npick_r);
      k_nxt       = '0;
    end

    // Output register: drop a taken beat, load a new one
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.res_out) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = res_st;
      out_evv_nxt   = 1'b0;
      out_id_nxt    = '0;
      out_usage_nxt = usage_r;
      out_res_nxt   = grt_pkg::TOTAL_W'(res_cnt_r);
      out_ev_nxt    = grt_pkg::TOTAL_W'(ev_cnt_r);
      out_last_nxt  = 1'b1;
    end

    if (cmd.ev_out) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = grt_pkg::ST_DONE;
      out_evv_nxt   = 1'b1;
      out_id_nxt    = grt_pkg::ID_FIELD_W'(pk_id);
      out_usage_nxt = usage_r;
      out_res_nxt   = grt_pkg::TOTAL_W'(res_cnt_r);
      out_ev_nxt    = grt_pkg::TOTAL_W'(ev_cnt_r);
      out_last_nxt  = ev_last;
      k_nxt         = k_r + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= grt_pkg::BUDGET_RST;
      thr_r       <= grt_pkg::THRESHOLD_RST;
      tgt_r       <= grt_pkg::TARGET_RST;
      idle_r      <= grt_pkg::IDLE_RST;
      ent_cnt_r   <= '0;
      cur_frame_r <= '0;
      usage_r     <= '0;
      res_cnt_r   <= '0;
      ev_cnt_r    <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      hit_r       <= 1'b0;
      npick_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      op_r        <= grt_pkg::OP_FRAME_START;
      pre_st_r    <= grt_pkg::ST_DONE;
    end else begin
      budget_r    <= budget_nxt;
      thr_r       <= thr_nxt;
      tgt_r       <= tgt_nxt;
      idle_r      <= idle_nxt;
      ent_cnt_r   <= ent_cnt_nxt;
      cur_frame_r <= cur_frame_nxt;
      usage_r     <= usage_nxt;
      res_cnt_r   <= res_cnt_nxt;
      ev_cnt_r    <= ev_cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      dv_r        <= dv_nxt;
      hit_r       <= hit_nxt;
      npick_r     <= npick_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      pre_st_r    <= pre_st_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    size_r      <= size_nxt;
    prio_r      <= prio_nxt;
    arg_r       <= arg_nxt;
    dv_idx_r    <= dv_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_res_r   <= hit_res_nxt;
    hit_size_r  <= hit_size_nxt;
    acc_r       <= acc_nxt;
    need_r      <= need_nxt;
    prod_thr_r  <= prod_thr_nxt;
    prod_tgt_r  <= prod_tgt_nxt;
    out_st_r    <= out_st_nxt;
    out_evv_r   <= out_evv_nxt;
    out_id_r    <= out_id_nxt;
    out_usage_r <= out_usage_nxt;
    out_res_r   <= out_res_nxt;
    out_ev_r    <= out_ev_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_evicted_valid  = out_evv_r;
  assign out_evicted_id     = out_id_r;
  assign out_usage_total    = out_usage_r;
  assign out_resident_total = out_res_r;
  assign out_evicted_total  = out_ev_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_out |-> ((CNT_W + 1)'(res_cnt_r) + (CNT_W + 1)'(ev_cnt_r)) ==
                    (CNT_W + 1)'(ent_cnt_r))
    else $error("resident and evicted counts disagree with entry count");

  a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    npick_r <= PK_CW'(MAX_EVICT))
    else $error("eviction pick count beyond limit");

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_evict_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ev_out |-> (npick_r != '0) && (k_r < npick_r))
    else $error("eviction beat without a picked entry");

  a_evicted_id_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evv_r) |-> (out_id_r != '0))
    else $error("evicted beat carries null handle");
`endif

endmodule
